[hw/rtl/point_dot_clustering_core_assert.svh]
// Assertion macros shared by the clustering core.
`ifndef POINT_DOT_CLUSTERING_CORE_ASSERT_SVH
`define POINT_DOT_CLUSTERING_CORE_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define PDC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A trigger that must be followed in the next cycle by a consequence.
`define PDC_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdc_pkg.sv]
package pdc_pkg;

  // Sizes of the point store and the dot table.
  localparam int MAX_POINTS = 1024;
  localparam int MAX_DOTS   = 64;
  localparam int COORD_BITS = 20;

  localparam int POINT_AW  = $clog2(MAX_POINTS);
  localparam int PT_CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DOT_W     = $clog2(MAX_DOTS);
  localparam int DOT_CNT_W = $clog2(MAX_DOTS + 1);

  // Fixed field widths of the transactions and registers.
  localparam int TOL_W    = 20;
  localparam int MINPT_W  = 11;
  localparam int KIND_W   = 2;
  localparam int LABEL_W  = 6;
  localparam int MCOUNT_W = 11;
  localparam int ORD_W    = 6;
  localparam int STAT_W   = 2;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 20;

  // Distance arithmetic widths.
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int TOL2_W = 2 * TOL_W;
  localparam int CMP_W  = (SUM_W > TOL2_W) ? SUM_W : TOL2_W;

  // Command codes.
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STAT_W-1:0] STAT_STORE_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_TOLERANCE  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_POINTS = 2'd1;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LABEL_W-1:0]  label;
    logic [MCOUNT_W-1:0] member_count;
    logic [ORD_W-1:0]    ordinal;
    logic [STAT_W-1:0]   status;
    logic                last;
  } out_item_t;

  // One stored point handed to the distance pipeline.
  typedef struct packed {
    logic                         valid;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic [DOT_W-1:0]             label;
  } dist_req_t;

  // Distance pipeline status back to the sequencer.
  typedef struct packed {
    logic             busy;
    logic             hit;
    logic [DOT_W-1:0] label;
  } dist_res_t;

endpackage

[hw/rtl/pdc_dist.sv]
module pdc_dist (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pdc_pkg::dist_req_t                    req,
  input  logic signed [pdc_pkg::COORD_BITS-1:0] qx,
  input  logic signed [pdc_pkg::COORD_BITS-1:0] qy,
  input  logic [pdc_pkg::TOL2_W-1:0]            tol2,
  output pdc_pkg::dist_res_t                    res
);
  import pdc_pkg::*;

  logic signed [COORD_BITS:0] dxa, dxb, dya, dyb;
  logic [COORD_BITS-1:0]      adx, ady;
  logic [CMP_W-1:0]           sum_w;

  logic                  s1_v_r, s2_v_r, s3_v_r;
  logic [COORD_BITS-1:0] s1_adx_r, s1_ady_r;
  logic [DOT_W-1:0]      s1_lbl_r, s2_lbl_r, s3_lbl_r;
  logic [SQ_W-1:0]       s2_sqx_r, s2_sqy_r;
  logic                  s3_hit_r;

  // Absolute differences: both subtraction orders, pick the non-negative one.
  always_comb begin
    dxa = {req.px[COORD_BITS-1], req.px} - {qx[COORD_BITS-1], qx};
    dxb = {qx[COORD_BITS-1], qx} - {req.px[COORD_BITS-1], req.px};
    dya = {req.py[COORD_BITS-1], req.py} - {qy[COORD_BITS-1], qy};
    dyb = {qy[COORD_BITS-1], qy} - {req.py[COORD_BITS-1], req.py};
    adx = dxa[COORD_BITS] ? dxb[COORD_BITS-1:0] : dxa[COORD_BITS-1:0];
    ady = dya[COORD_BITS] ? dyb[COORD_BITS-1:0] : dya[COORD_BITS-1:0];
    sum_w = CMP_W'(s2_sqx_r) + CMP_W'(s2_sqy_r);
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Stage data: differences, squares, then the compare against the squared tolerance.
  always_ff @(posedge clk) begin
    s1_adx_r <= adx;
    s1_ady_r <= ady;
    s1_lbl_r <= req.label;
    s2_sqx_r <= SQ_W'(s1_adx_r) * SQ_W'(s1_adx_r);
    s2_sqy_r <= SQ_W'(s1_ady_r) * SQ_W'(s1_ady_r);
    s2_lbl_r <= s1_lbl_r;
    s3_hit_r <= s2_v_r && (sum_w < CMP_W'(tol2));
    s3_lbl_r <= s2_lbl_r;
  end

  assign res.busy  = s1_v_r | s2_v_r | s3_v_r;
  assign res.hit   = s3_v_r & s3_hit_r;
  assign res.label = s3_lbl_r;

endmodule

[hw/rtl/point_dot_clustering_core.sv]
// Channel  Handshake              Payload
// in_      in_valid / in_stall    in_data: cmd, pos_x, pos_y
// out_     out_valid / out_stall  out_data: kind, label, member_count, ordinal, status, last
// cfg_     cfg_we                 cfg_addr, cfg_data
//
// An add holds in_stall while stored points are read, one per cycle, and pass the read and
// three distance stages, then while the pipeline drains and the sequencer decides, the
// count of a joined existing dot is written and the output loads. A store-full add loads
// directly. A finish reads, then checks, the count of each dot, then emits its last result.
// A result waits in the output register while out_stall is high; the next load waits too.
// Reset is synchronous with no clearing pass: only entries below the live counts are read.
`include "point_dot_clustering_core_assert.svh"

module point_dot_clustering_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  pdc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output pdc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [pdc_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [pdc_pkg::CFG_DW-1:0]    cfg_data
);
  import pdc_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b00000001,
    ST_SCAN    = 8'b00000010,
    ST_DECIDE  = 8'b00000100,
    ST_CNT_WR  = 8'b00001000,
    ST_EMIT    = 8'b00010000,
    ST_FIN_RD  = 8'b00100000,
    ST_FIN_CHK = 8'b01000000,
    ST_FIN_END = 8'b10000000
  } state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic [DOT_W-1:0]             label;
  } pt_word_t;

  state_t state_r;

  // Configuration and sequencer registers.
  logic [TOL_W-1:0]     tol_r;
  logic [TOL2_W-1:0]    tol2_r;
  logic [MINPT_W-1:0]   min_points_r;
  logic [PT_CNT_W-1:0]  stored_r;
  logic [DOT_CNT_W-1:0] dot_total_r;
  logic [PT_CNT_W-1:0]  scan_i_r;
  logic [DOT_CNT_W-1:0] best_r;
  logic [DOT_CNT_W-1:0] fin_d_r;
  logic [ORD_W-1:0]     ord_r;
  logic signed [COORD_BITS-1:0] qx_r, qy_r;
  out_item_t            res_r;
  out_item_t            pend_r;
  logic                 pend_v_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // Memories.
  pt_word_t             pt_mem [MAX_POINTS];
  pt_word_t             pt_rdata_r;
  logic                 pt_rvalid_r;
  logic [PT_CNT_W-1:0]  cnt_mem [MAX_DOTS];
  logic [PT_CNT_W-1:0]  cnt_rdata_r;

  logic                 in_accept, out_free, out_load, scan_issue, scan_done;
  logic                 new_dot, table_full, fin_hit, fin_more;
  logic                 pt_we, cnt_re, cnt_we;
  logic [DOT_W-1:0]     cnt_raddr, cnt_waddr;
  logic [PT_CNT_W-1:0]  cnt_wdata;
  dist_req_t            dreq;
  dist_res_t            dres;

  // Handshake and memory control decode.
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    in_accept  = in_valid && !in_stall;
    out_free   = !out_valid_r || !out_stall;
    scan_issue = (state_r == ST_SCAN) && (scan_i_r != stored_r);
    scan_done  = (state_r == ST_SCAN) && !scan_issue && !pt_rvalid_r && !dres.busy;
    new_dot    = (best_r == DOT_CNT_W'(MAX_DOTS));
    table_full = (dot_total_r >= DOT_CNT_W'(MAX_DOTS));
    fin_more   = (fin_d_r != dot_total_r);
    fin_hit    = (MCOUNT_W'(cnt_rdata_r) > MCOUNT_W'(min_points_r));
    // The output register takes a new transaction in these cases only.
    out_load   = out_free && ((state_r == ST_EMIT) || (state_r == ST_FIN_END) ||
                              ((state_r == ST_FIN_CHK) && fin_hit && pend_v_r));

    pt_we     = (state_r == ST_DECIDE) && !(new_dot && table_full);
    cnt_re    = 1'b0;
    cnt_raddr = fin_d_r[DOT_W-1:0];
    cnt_we    = 1'b0;
    cnt_waddr = best_r[DOT_W-1:0];
    cnt_wdata = cnt_rdata_r + PT_CNT_W'(1);
    case (state_r)
      ST_DECIDE: begin
        if (new_dot) begin
          cnt_we    = !table_full;
          cnt_waddr = dot_total_r[DOT_W-1:0];
          cnt_wdata = PT_CNT_W'(1);
        end else begin
          cnt_re    = 1'b1;
          cnt_raddr = best_r[DOT_W-1:0];
        end
      end
      ST_CNT_WR: begin
        cnt_we = 1'b1;
      end
      ST_FIN_RD: begin
        cnt_re = fin_more;
      end
      default: begin
      end
    endcase
  end

  // Point store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[stored_r[POINT_AW-1:0]] <= '{x: qx_r, y: qy_r,
                                          label: new_dot ? dot_total_r[DOT_W-1:0]
                                                         : best_r[DOT_W-1:0]};
    end
    if (scan_issue) begin
      pt_rdata_r <= pt_mem[scan_i_r[POINT_AW-1:0]];
    end
  end

  // Dot count memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_r <= cnt_mem[cnt_raddr];
    end
  end

  // Stored points stream into the distance pipeline.
  always_comb begin
    dreq.valid = pt_rvalid_r;
    dreq.px    = pt_rdata_r.x;
    dreq.py    = pt_rdata_r.y;
    dreq.label = pt_rdata_r.label;
  end

  pdc_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .qx    (qx_r),
    .qy    (qy_r),
    .tol2  (tol2_r),
    .res   (dres)
  );

  // Squared tolerance, refreshed every cycle from the register.
  always_ff @(posedge clk) begin
    tol2_r <= TOL2_W'(tol_r) * TOL2_W'(tol_r);
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tol_r        <= TOL_W'(16);
      min_points_r <= '0;
      stored_r     <= '0;
      dot_total_r  <= '0;
      pt_rvalid_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pt_rvalid_r <= scan_issue;

      if (cfg_we) begin
        if (cfg_addr == CFG_TOLERANCE) begin
          tol_r <= cfg_data[TOL_W-1:0];
        end else if (cfg_addr == CFG_MIN_POINTS) begin
          min_points_r <= cfg_data[MINPT_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            qx_r <= in_data.pos_x;
            qy_r <= in_data.pos_y;
            if (in_data.cmd == CMD_FINISH) begin
              fin_d_r  <= '0;
              ord_r    <= '0;
              pend_v_r <= 1'b0;
              state_r  <= ST_FIN_RD;
            end else if (stored_r >= PT_CNT_W'(MAX_POINTS)) begin
              res_r   <= '{kind: KIND_ASSIGN, label: '0,
                           member_count: MCOUNT_W'(stored_r), ordinal: '0,
                           status: STAT_STORE_FULL, last: 1'b1};
              state_r <= ST_EMIT;
            end else begin
              scan_i_r <= '0;
              best_r   <= DOT_CNT_W'(MAX_DOTS);
              state_r  <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_i_r <= scan_i_r + PT_CNT_W'(1);
          end
          // Keep the earliest-created dot among the hits.
          if (dres.hit && (DOT_CNT_W'(dres.label) < best_r)) begin
            best_r <= DOT_CNT_W'(dres.label);
          end
          if (scan_done) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (new_dot && table_full) begin
            res_r   <= '{kind: KIND_ASSIGN, label: '0,
                         member_count: MCOUNT_W'(stored_r), ordinal: '0,
                         status: STAT_TABLE_FULL, last: 1'b1};
            state_r <= ST_EMIT;
          end else begin
            stored_r <= stored_r + PT_CNT_W'(1);
            res_r    <= '{kind: KIND_ASSIGN,
                          label: new_dot ? LABEL_W'(dot_total_r) : LABEL_W'(best_r),
                          member_count: MCOUNT_W'(stored_r + PT_CNT_W'(1)),
                          ordinal: '0, status: STAT_OK, last: 1'b1};
            if (new_dot) begin
              dot_total_r <= dot_total_r + DOT_CNT_W'(1);
              state_r     <= ST_EMIT;
            end else begin
              state_r <= ST_CNT_WR;
            end
          end
        end
        ST_CNT_WR: begin
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_r  <= res_r;
            state_r     <= ST_IDLE;
          end
        end
        ST_FIN_RD: begin
          state_r <= fin_more ? ST_FIN_CHK : ST_FIN_END;
        end
        ST_FIN_CHK: begin
          // A survivor is held back one step so the final one can carry last.
          if (!fin_hit) begin
            fin_d_r <= fin_d_r + DOT_CNT_W'(1);
            state_r <= ST_FIN_RD;
          end else if (!pend_v_r || out_free) begin
            if (pend_v_r) begin
              out_data_r  <= pend_r;
            end
            pend_r   <= '{kind: KIND_REPORT, label: LABEL_W'(fin_d_r),
                          member_count: MCOUNT_W'(cnt_rdata_r), ordinal: ord_r,
                          status: STAT_OK, last: 1'b0};
            pend_v_r <= 1'b1;
            ord_r    <= ord_r + ORD_W'(1);
            fin_d_r  <= fin_d_r + DOT_CNT_W'(1);
            state_r  <= ST_FIN_RD;
          end
        end
        ST_FIN_END: begin
          if (out_free) begin
            if (pend_v_r) begin
              out_data_r <= '{kind: pend_r.kind, label: pend_r.label,
                              member_count: pend_r.member_count, ordinal: pend_r.ordinal,
                              status: pend_r.status, last: 1'b1};
            end else begin
              out_data_r <= '{kind: KIND_NONE, label: '0, member_count: '0,
                              ordinal: '0, status: STAT_OK, last: 1'b1};
            end
            pend_v_r    <= 1'b0;
            stored_r    <= '0;
            dot_total_r <= '0;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and its stores.
  `PDC_ASSERT_ALWAYS(a_store_bound, stored_r <= PT_CNT_W'(MAX_POINTS), "point count overflow")
  `PDC_ASSERT_ALWAYS(a_table_bound, dot_total_r <= DOT_CNT_W'(MAX_DOTS), "dot total overflow")
  `PDC_ASSERT_NEXT(a_best_mono, state_r == ST_SCAN, best_r <= $past(best_r), "best label rose")
  `PDC_ASSERT_NEXT(a_new_dot, state_r == ST_DECIDE && new_dot && !table_full, dot_total_r == $past(dot_total_r) + DOT_CNT_W'(1), "new dot not counted")
  `PDC_ASSERT_NEXT(a_finish_clear, state_r == ST_FIN_END && out_free, stored_r == '0 && dot_total_r == '0 && out_valid_r, "finish did not clear")

endmodule

[dv/tb_point_dot_clustering_core.sv]
module tb_point_dot_clustering_core;
  import pdc_pkg::*;

  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 180;
  localparam int PRINT_CAP    = 40;
  localparam int COORD_MAX    = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN    = -(1 << (COORD_BITS - 1));

  localparam logic [TOL_W-1:0]  TOL_MAX   = '1;
  // Index past the two registers; writes there must be ignored.
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr  = '0;
  logic [CFG_DW-1:0]  cfg_data  = '0;

  // Stimulus waiting to be sent and results the clustering should produce.
  in_item_t  items_to_send[$];
  out_item_t dot_results_due[$];

  // Shadow copy of the point store, the dot table and the registers.
  int               pt_x[MAX_POINTS];
  int               pt_y[MAX_POINTS];
  int               pt_dot[MAX_POINTS];
  int               dot_members[MAX_DOTS];
  int               num_points   = 0;
  int               num_dots     = 0;
  logic [TOL_W-1:0]   join_tol     = TOL_W'(16);
  logic [MINPT_W-1:0] report_floor = '0;

  // Idle odds in percent, set per phase.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int in_gap_left   = 0;
  int out_hold_left = 0;

  int mismatches     = 0;
  int items_accepted = 0;
  int results_seen   = 0;
  int settings_used  = 0;
  int reports_seen   = 0;
  int empties_seen   = 0;
  int store_full_seen = 0;
  int table_full_seen = 0;
  int quiet_cycles   = 0;

  point_dot_clustering_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Appends one transaction to the stimulus queue.
  function automatic void queue_item(in_item_t it);
    items_to_send = {items_to_send, it};
  endfunction

  // Appends one result to the list of expected results.
  function automatic void expect_result(out_item_t r);
    dot_results_due = {dot_results_due, r};
  endfunction

  // Works out the results of one accepted transaction and updates the shadow state.
  function automatic void predict_dot_results(in_item_t item);
    out_item_t res;
    int        x, y, i, best, survivors, ord;
    longint    dx, dy, reach_sq;
    res = '0;
    if (item.cmd == CMD_ADD) begin
      res.kind = KIND_ASSIGN;
      res.last = 1'b1;
      res.member_count = MCOUNT_W'(num_points);
      if (num_points >= MAX_POINTS) begin
        res.status = STAT_STORE_FULL;
      end else begin
        x = $signed(item.pos_x);
        y = $signed(item.pos_y);
        reach_sq = longint'(join_tol) * longint'(join_tol);
        best = MAX_DOTS;
        // The earliest dot with any member strictly inside the tolerance wins.
        for (i = 0; i < num_points; i++) begin
          dx = longint'(pt_x[i] - x);
          dy = longint'(pt_y[i] - y);
          if (dx * dx + dy * dy < reach_sq && pt_dot[i] < best) best = pt_dot[i];
        end
        if (best == MAX_DOTS && num_dots >= MAX_DOTS) begin
          res.status = STAT_TABLE_FULL;
        end else begin
          if (best == MAX_DOTS) begin
            best = num_dots;
            num_dots++;
          end
          pt_x[num_points] = x;
          pt_y[num_points] = y;
          pt_dot[num_points] = best;
          num_points++;
          dot_members[best]++;
          res.label = LABEL_W'(best);
          res.member_count = MCOUNT_W'(num_points);
        end
      end
      expect_result(res);
    end else begin
      survivors = 0;
      for (i = 0; i < num_dots; i++) begin
        if (dot_members[i] > int'(report_floor)) survivors++;
      end
      if (survivors == 0) begin
        res.kind = KIND_NONE;
        res.last = 1'b1;
        expect_result(res);
      end else begin
        ord = 0;
        for (i = 0; i < num_dots; i++) begin
          if (dot_members[i] > int'(report_floor)) begin
            res.kind = KIND_REPORT;
            res.label = LABEL_W'(i);
            res.member_count = MCOUNT_W'(dot_members[i]);
            res.ordinal = ORD_W'(ord);
            res.status = STAT_OK;
            res.last = (ord == survivors - 1);
            expect_result(res);
            ord++;
          end
        end
      end
      // A finish empties the store and the table.
      for (i = 0; i < MAX_DOTS; i++) dot_members[i] = 0;
      num_points = 0;
      num_dots = 0;
    end
  endfunction

  task automatic flag_mismatch(string what);
    if (mismatches < PRINT_CAP) $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  task automatic check_field(string name, int idx, logic [MCOUNT_W-1:0] got,
                             logic [MCOUNT_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d: %s is %0d, expected %0d", idx, name, got, want));
  endtask

  // Compares one accepted result against the oldest expectation.
  task automatic compare_result(out_item_t got);
    out_item_t want;
    results_seen++;
    if (dot_results_due.size() == 0) begin
      flag_mismatch($sformatf("result %0d arrived with nothing pending (kind %0d label %0d)",
                              results_seen, got.kind, got.label));
    end else begin
      want = dot_results_due.pop_front();
      if (want.kind == KIND_REPORT) reports_seen++;
      if (want.kind == KIND_NONE) empties_seen++;
      if (want.status == STAT_STORE_FULL) store_full_seen++;
      if (want.status == STAT_TABLE_FULL) table_full_seen++;
      check_field("kind", results_seen, MCOUNT_W'(got.kind), MCOUNT_W'(want.kind));
      check_field("label", results_seen, MCOUNT_W'(got.label), MCOUNT_W'(want.label));
      check_field("member_count", results_seen, got.member_count, want.member_count);
      check_field("ordinal", results_seen, MCOUNT_W'(got.ordinal), MCOUNT_W'(want.ordinal));
      check_field("status", results_seen, MCOUNT_W'(got.status), MCOUNT_W'(want.status));
      check_field("last", results_seen, MCOUNT_W'(got.last), MCOUNT_W'(want.last));
    end
  endtask

  // Driver: presents queued transactions, holding each one while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_dot_results(in_data);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_valid <= 1'b0;
          in_gap_left <= in_gap_left - 1;
        end else if (items_to_send.size() != 0 && $urandom_range(0, 99) < in_gap_pct) begin
          in_valid <= 1'b0;
          in_gap_left <= $urandom_range(0, 10);
        end else if (items_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= items_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output in bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (out_hold_left > 0) begin
        out_stall <= 1'b1;
        out_hold_left <= out_hold_left - 1;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        out_stall <= 1'b1;
        out_hold_left <= $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("point_dot_clustering_core verification failed");
        $finish;
      end
    end
  end

  function automatic int clamp_coord(int v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
  endfunction

  function automatic in_item_t add_item(int x, int y);
    in_item_t it;
    it.cmd = CMD_ADD;
    it.pos_x = COORD_BITS'(clamp_coord(x));
    it.pos_y = COORD_BITS'(clamp_coord(y));
    return it;
  endfunction

  // The coordinates of a finish carry random bits that must be ignored.
  function automatic in_item_t finish_item();
    in_item_t it;
    it.cmd = CMD_FINISH;
    it.pos_x = COORD_BITS'($urandom);
    it.pos_y = COORD_BITS'($urandom);
    return it;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  // Points scattered around a few centers, some stray noise, then a finish.
  task automatic queue_sequence(int n_adds, int spread);
    int cx[4], cy[4];
    int k, j, n_ctr;
    n_ctr = $urandom_range(1, 4);
    for (k = 0; k < 4; k++) begin
      cx[k] = rand_coord();
      cy[k] = rand_coord();
    end
    for (k = 0; k < n_adds; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(add_item(rand_coord(), rand_coord()));
      end else begin
        j = $urandom_range(0, n_ctr - 1);
        queue_item(add_item(
          cx[j] + int'($urandom_range(0, 2 * spread)) - spread,
          cy[j] + int'($urandom_range(0, 2 * spread)) - spread));
      end
    end
    queue_item(finish_item());
  endtask

  // Returns once nothing is queued, in flight or expected.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_to_send.size() != 0 || in_valid || dot_results_due.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TOLERANCE) join_tol = val[TOL_W-1:0];
    else if (idx == CFG_MIN_POINTS) report_floor = val[MINPT_W-1:0];
  endtask

  task automatic apply_setting(logic [TOL_W-1:0] tol, logic [CFG_DW-1:0] floor_word);
    wait_drained();
    write_reg(CFG_TOLERANCE, CFG_DW'(tol));
    write_reg(CFG_MIN_POINTS, floor_word);
    settings_used++;
  endtask

  initial begin
    int                 k, n, phase, random_items, spread;
    logic [TOL_W-1:0]   tol;
    logic [CFG_DW-1:0]  floor_word;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: finish on an empty store, then points around the
    // tolerance boundary, ties between two dots, and the coordinate corners.
    queue_item(finish_item());
    queue_item(add_item(0, 0));
    queue_item(add_item(15, 0));
    queue_item(add_item(0, 16));
    queue_item(add_item(8, 8));
    queue_item(add_item(3, 30));
    queue_item(add_item(-15, 0));
    queue_item(add_item(COORD_MAX, COORD_MAX));
    queue_item(add_item(COORD_MIN, COORD_MIN));
    queue_item(add_item(COORD_MIN, COORD_MAX));
    queue_item(add_item(COORD_MAX, COORD_MIN));
    queue_item(add_item(COORD_MAX, COORD_MAX - 15));
    queue_item(finish_item());

    // Largest tolerance against the widest possible distances.
    apply_setting(TOL_MAX, CFG_DW'(0));
    queue_item(add_item(COORD_MIN, COORD_MIN));
    queue_item(add_item(COORD_MAX, COORD_MAX));
    queue_item(add_item(0, 0));
    queue_item(finish_item());

    // Zero tolerance keeps identical points apart; the minimum count word
    // carries junk above its width, and a write to the spare index is dropped.
    wait_drained();
    write_reg(CFG_TOLERANCE, '0);
    write_reg(CFG_MIN_POINTS, {9'h1a5, 11'd1});
    write_reg(CFG_SPARE, '1);
    settings_used++;
    queue_item(add_item(5, 5));
    queue_item(add_item(5, 5));
    queue_item(finish_item());

    // Random phases: each picks a register setting and idle odds, then runs
    // one or two clustered sequences, sometimes a bare finish.
    random_items = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase % 6)
        0: tol = TOL_W'(16);
        1: tol = '0;
        2: tol = TOL_W'(1);
        3: tol = TOL_MAX;
        4: tol = TOL_W'($urandom_range(2, 64));
        default: tol = TOL_W'($urandom_range(65, 50000));
      endcase
      case ($urandom_range(0, 5))
        0: floor_word = CFG_DW'(0);
        1: floor_word = CFG_DW'(1);
        2: floor_word = CFG_DW'(2);
        3: floor_word = CFG_DW'($urandom_range(3, 6));
        4: floor_word = CFG_DW'(1024);
        default: floor_word = CFG_DW'(2047);
      endcase
      spread = int'(tol) + int'(tol) / 2 + 3;
      apply_setting(tol, floor_word);
      in_gap_pct = pick_pct();
      out_stall_pct = pick_pct();
      for (k = $urandom_range(1, 2); k > 0; k--) begin
        n = $urandom_range(0, 26);
        queue_sequence(n, spread);
        random_items += n + 1;
      end
      phase++;
    end

    // Overflow the dot table: with zero tolerance every point opens a dot.
    apply_setting('0, CFG_DW'(0));
    for (k = 0; k < MAX_DOTS + 6; k++) begin
      if (k % 9 == 8) queue_item(items_to_send[$]);
      else queue_item(add_item(rand_coord(), rand_coord()));
    end
    queue_item(finish_item());
    queue_item(finish_item());

    // Final stretch without any idling on either side.
    apply_setting(TOL_W'(300), CFG_DW'(1));
    in_gap_pct = 0;
    out_stall_pct = 0;
    queue_sequence(20, 450);
    queue_sequence(15, 450);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d input transactions and %0d results over %0d register settings.",
             items_accepted, results_seen, settings_used);
    $display("Saw %0d dot reports, %0d empty finishes, %0d store-full and %0d table-full drops.",
             reports_seen, empties_seen, store_full_seen, table_full_seen);
    if (mismatches == 0) begin
      $display("point_dot_clustering_core verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("point_dot_clustering_core verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_dist.sv
hw/rtl/point_dot_clustering_core.sv
dv/tb_point_dot_clustering_core.sv
